// File: rtl/core/lbgf_pkg.sv
`default_nettype none

package lbgf_pkg;

    localparam int BAR_COUNT_DEF   = 8;
    localparam int LEDS_IN_BAR_DEF = 8;

    localparam int BAR_W      = 3;
    localparam int LEVEL_W    = 12;
    localparam int LED_IDX_W  = 6;
    localparam int HUE_W      = 8;
    localparam int VALUE_W    = 8;
    localparam int FADE_W     = 8;
    localparam int ALPHA_W    = 9;
    localparam int PCT_W      = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;
    localparam logic [PCT_W-1:0]   PCT_MAX   = 7'd100;

    // floor(x / 100) == (x * 20972) >> 21 for x below 43690
    localparam logic [14:0] DIV100_MUL   = 15'd20972;
    localparam int          DIV100_SHIFT = 21;

    localparam logic [FADE_W-1:0]  FADE_STEP_RST = 8'd10;
    localparam logic [ALPHA_W-1:0] ALPHA_RST     = 9'd38;
    localparam logic [PCT_W-1:0]   PCT_RST       = 7'd60;
    localparam logic [HUE_W-1:0]   HUE_BASE_RST  = 8'd200;
    localparam logic [HUE_W-1:0]   HUE_STEP_RST  = 8'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FADE_STEP  = 3'd0,
        CFG_ALPHA      = 3'd1,
        CFG_PERCENT    = 3'd2,
        CFG_HUE_BASE   = 3'd3,
        CFG_HUE_STEP   = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [FADE_W-1:0]  fade_step;
        logic [ALPHA_W-1:0] alpha;
        logic [PCT_W-1:0]   percent;
        logic [HUE_W-1:0]   hue_base;
        logic [HUE_W-1:0]   hue_step;
    } cfg_t;

    // one smoothed bar update handed from front to back
    typedef struct packed {
        logic [BAR_W-1:0]   bar;
        logic [LEVEL_W-1:0] level;
        logic [HUE_W-1:0]   hue;
    } job_t;

endpackage

`default_nettype wire

// File: rtl/core/lbgf_if.sv
`default_nettype none

interface lbgf_in_if;
    logic                          valid;
    logic                          ready;
    logic [lbgf_pkg::BAR_W-1:0]    bar_index;
    logic [lbgf_pkg::LEVEL_W-1:0]  desired_level;

    modport source (output valid, bar_index, desired_level, input ready);
    modport sink   (input valid, bar_index, desired_level, output ready);
endinterface

interface lbgf_out_if;
    logic                           valid;
    logic                           ready;
    logic [lbgf_pkg::LED_IDX_W-1:0] led_index;
    logic [lbgf_pkg::HUE_W-1:0]     hue;
    logic [lbgf_pkg::VALUE_W-1:0]   value;
    logic                           last_led;

    modport source (output valid, led_index, hue, value, last_led, input ready);
    modport sink   (input valid, led_index, hue, value, last_led, output ready);
endinterface

`default_nettype wire

// File: rtl/core/lbgf_front.sv
`default_nettype none

module lbgf_front #(
    parameter int BAR_COUNT   = lbgf_pkg::BAR_COUNT_DEF,
    parameter int LEDS_IN_BAR = lbgf_pkg::LEDS_IN_BAR_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    lbgf_in_if.sink              level,
    input  lbgf_pkg::cfg_t       cfg,
    output logic                 push,
    output lbgf_pkg::job_t       push_job,
    input  logic                 full
);

    localparam int BAR_LIM   = 1 << lbgf_pkg::BAR_W;
    localparam int BARS_USED = (BAR_COUNT < BAR_LIM) ? BAR_COUNT : BAR_LIM;
    localparam int SW        = (BARS_USED > 1) ? $clog2(BARS_USED) : 1;
    localparam logic [14:0] CAP_V = 15'(LEDS_IN_BAR * 256);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_MUL  = 3'b010,
        F_ADD  = 3'b100
    } fstate_t;

    fstate_t                         state_reg, state_next;
    logic [lbgf_pkg::BAR_W-1:0]      bar_reg;
    logic [lbgf_pkg::LEVEL_W-1:0]    d_reg;
    logic [20:0]                     p_old_reg;
    logic [20:0]                     p_new_reg;
    logic [lbgf_pkg::HUE_W-1:0]      hue_reg;
    logic [lbgf_pkg::LEVEL_W-1:0]    smooth_reg [BARS_USED];

    logic                            accept;
    logic                            bar_ok;
    logic [lbgf_pkg::LEVEL_W-1:0]    d_sat;
    logic [lbgf_pkg::ALPHA_W-1:0]    a_sat;
    logic [lbgf_pkg::ALPHA_W-1:0]    a_inv;
    logic [lbgf_pkg::LEVEL_W-1:0]    s_old;
    logic [21:0]                     sum;
    logic [13:0]                     s_sh;
    logic [13:0]                     s_cap;
    logic [lbgf_pkg::LEVEL_W-1:0]    s_new;
    logic [10:0]                     hue_prod;

    assign level.ready = (state_reg == F_IDLE);
    assign accept      = level.valid && level.ready;
    assign bar_ok      = {4'b0, level.bar_index} < 7'(BAR_COUNT);

    always_comb
    begin
        if ({3'b0, level.desired_level} > CAP_V)
            d_sat = CAP_V[lbgf_pkg::LEVEL_W-1:0];
        else
            d_sat = level.desired_level;

        a_sat = (cfg.alpha > lbgf_pkg::ALPHA_ONE) ? lbgf_pkg::ALPHA_ONE : cfg.alpha;
        a_inv = lbgf_pkg::ALPHA_ONE - a_sat;
        s_old = smooth_reg[bar_reg[SW-1:0]];

        sum   = {1'b0, p_old_reg} + {1'b0, p_new_reg} + 22'd128;
        s_sh  = sum[21:8];
        s_cap = ({1'b0, s_sh} > CAP_V) ? CAP_V[13:0] : s_sh;
        // weighted mean of two 12-bit levels stays within 12 bits
        s_new = s_cap[lbgf_pkg::LEVEL_W-1:0];

        hue_prod = 11'(cfg.hue_step) * 11'(bar_reg);
    end

    assign push           = (state_reg == F_ADD) && !full;
    assign push_job.bar   = bar_reg;
    assign push_job.level = s_new;
    assign push_job.hue   = hue_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept && bar_ok)
                    state_next = F_MUL;
            end
            F_MUL:
            begin
                state_next = F_ADD;
            end
            F_ADD:
            begin
                if (!full)
                    state_next = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            for (int i = 0; i < BARS_USED; i++)
                smooth_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (push)
                smooth_reg[bar_reg[SW-1:0]] <= s_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && bar_ok)
        begin
            bar_reg <= level.bar_index;
            d_reg   <= d_sat;
        end
        if (state_reg == F_MUL)
        begin
            p_old_reg <= 21'(s_old) * 21'(a_inv);
            p_new_reg <= 21'(d_reg) * 21'(a_sat);
            hue_reg   <= cfg.hue_base - hue_prod[lbgf_pkg::HUE_W-1:0];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/lbgf_queue.sv
`default_nettype none

module lbgf_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  lbgf_pkg::job_t  push_job,
    output logic            full,
    input  logic            pop,
    output lbgf_pkg::job_t  head_job,
    output logic            not_empty
);

    lbgf_pkg::job_t  slot_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head_job  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

endmodule

`default_nettype wire

// File: rtl/core/lbgf_back.sv
`default_nettype none

module lbgf_back #(
    parameter int BAR_COUNT   = lbgf_pkg::BAR_COUNT_DEF,
    parameter int LEDS_IN_BAR = lbgf_pkg::LEDS_IN_BAR_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  lbgf_pkg::cfg_t  cfg,
    input  logic            q_valid,
    input  lbgf_pkg::job_t  q_job,
    output logic            q_pop,
    lbgf_out_if.source      led
);

    localparam int BAR_LIM   = 1 << lbgf_pkg::BAR_W;
    localparam int BARS_USED = (BAR_COUNT < BAR_LIM) ? BAR_COUNT : BAR_LIM;
    localparam int SW        = (BARS_USED > 1) ? $clog2(BARS_USED) : 1;
    localparam int DEPTH     = BARS_USED * LEDS_IN_BAR;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RW        = (LEDS_IN_BAR > 1) ? $clog2(LEDS_IN_BAR) : 1;
    localparam logic [RW-1:0] ROW_LAST = RW'(LEDS_IN_BAR - 1);

    // brightness store, one row per bar
    logic [7:0]                      mem [DEPTH];
    logic [7:0]                      rd_data_reg;
    logic                            bar_valid_reg [BARS_USED];

    // walker over the rows of the current job
    logic                            busy_reg;
    lbgf_pkg::job_t                  job_reg;
    logic [RW-1:0]                   row_reg;

    logic                            s1_valid_reg;
    logic [AW-1:0]                   s1_addr_reg;
    logic [RW-1:0]                   s1_row_reg;
    logic [lbgf_pkg::LEVEL_W-1:0]    s1_level_reg;
    logic [lbgf_pkg::BAR_W-1:0]      s1_bar_reg;
    logic [lbgf_pkg::HUE_W-1:0]      s1_hue_reg;
    logic [lbgf_pkg::LED_IDX_W-1:0]  s1_idx_reg;
    logic                            s1_last_reg;

    logic                            s2_valid_reg;
    logic [14:0]                     s2_prod_reg;
    logic [lbgf_pkg::HUE_W-1:0]      s2_hue_reg;
    logic [lbgf_pkg::LED_IDX_W-1:0]  s2_idx_reg;
    logic                            s2_last_reg;

    logic                            out_valid_reg;
    logic [lbgf_pkg::LED_IDX_W-1:0]  out_idx_reg;
    logic [lbgf_pkg::HUE_W-1:0]      out_hue_reg;
    logic [lbgf_pkg::VALUE_W-1:0]    out_value_reg;
    logic                            out_last_reg;

    logic                            advance;
    logic                            issue;
    logic                            row_last;
    logic [11:0]                     flat_idx;
    logic [AW-1:0]                   rd_addr;
    logic [7:0]                      bright;
    logic [13:0]                     lo14;
    logic [13:0]                     hi14;
    logic [13:0]                     lvl14;
    logic [13:0]                     diff14;
    logic [7:0]                      target;
    logic [8:0]                      up_sum;
    logic [7:0]                      b_new;
    logic [lbgf_pkg::PCT_W-1:0]      pct;
    logic [29:0]                     quot;

    assign advance  = !out_valid_reg || led.ready;
    assign q_pop    = advance && !busy_reg && q_valid;
    assign issue    = advance && busy_reg;
    assign row_last = (row_reg == ROW_LAST);
    assign flat_idx = 12'(job_reg.bar) * 12'(LEDS_IN_BAR) + 12'(row_reg);
    assign rd_addr  = flat_idx[AW-1:0];

    always_comb
    begin
        // a bar never written yet reads as dark
        bright = bar_valid_reg[s1_bar_reg[SW-1:0]] ? rd_data_reg : 8'd0;

        lo14   = 14'({s1_row_reg, 8'h00});
        hi14   = lo14 + 14'd256;
        lvl14  = 14'(s1_level_reg);
        diff14 = lvl14 - lo14;
        if (lvl14 >= hi14)
            target = 8'd255;
        else if (lvl14 <= lo14)
            target = 8'd0;
        else
            target = diff14[7:0] - 8'd1;   // (f * 255) >> 8 is f - 1 for f in 1..255

        up_sum = {1'b0, bright} + {1'b0, cfg.fade_step};
        if (bright < target)
            b_new = (up_sum > {1'b0, target}) ? target : up_sum[7:0];
        else if (bright > target)
            b_new = ((bright - target) <= cfg.fade_step) ? target : bright - cfg.fade_step;
        else
            b_new = bright;

        pct  = (cfg.percent > lbgf_pkg::PCT_MAX) ? lbgf_pkg::PCT_MAX : cfg.percent;
        quot = 30'(s2_prod_reg) * 30'(lbgf_pkg::DIV100_MUL);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < BARS_USED; i++)
                bar_valid_reg[i] <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                busy_reg <= 1'b1;
                row_reg  <= '0;
            end
            else if (issue)
            begin
                row_reg <= RW'(row_reg + 1'b1);
                if (row_last)
                    busy_reg <= 1'b0;
            end
            if (advance)
            begin
                s1_valid_reg  <= issue;
                s2_valid_reg  <= s1_valid_reg;
                out_valid_reg <= s2_valid_reg;
                if (s1_valid_reg && s1_last_reg)
                    bar_valid_reg[s1_bar_reg[SW-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            job_reg <= q_job;
        if (issue)
        begin
            s1_addr_reg  <= rd_addr;
            s1_row_reg   <= row_reg;
            s1_level_reg <= job_reg.level;
            s1_bar_reg   <= job_reg.bar;
            s1_hue_reg   <= job_reg.hue;
            s1_idx_reg   <= flat_idx[lbgf_pkg::LED_IDX_W-1:0];
            s1_last_reg  <= row_last;
        end
        if (advance)
        begin
            s2_prod_reg   <= 15'(b_new) * 15'(pct);
            s2_hue_reg    <= s1_hue_reg;
            s2_idx_reg    <= s1_idx_reg;
            s2_last_reg   <= s1_last_reg;
            out_idx_reg   <= s2_idx_reg;
            out_hue_reg   <= s2_hue_reg;
            out_value_reg <= quot[lbgf_pkg::DIV100_SHIFT +: lbgf_pkg::VALUE_W];
            out_last_reg  <= s2_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
            mem[s1_addr_reg] <= b_new;
        if (issue)
            rd_data_reg <= mem[rd_addr];
    end

    assign led.valid     = out_valid_reg;
    assign led.led_index = out_idx_reg;
    assign led.hue       = out_hue_reg;
    assign led.value     = out_value_reg;
    assign led.last_led  = out_last_reg;

endmodule

`default_nettype wire

// File: rtl/core/led_bar_graph_fader_core.sv
// LED bar graph fader.
// level: one transfer carries a bar index and a requested height (Q.8, in LEDs).
//   Transfers for a bar index at or above BAR_COUNT are taken and dropped.
// led: LEDS_IN_BAR transfers follow each level transfer, one per LED in row
//   order, with led index, bar hue, faded and scaled value; last_led marks the
//   final LED of the bar.
// Registers are written via write_en / reg_index / write_data; the user must
//   write only while idle, which the block itself does not enforce.
// Front: latch, multiply, smooth and enqueue; one level item at a time.
// A two-entry job queue separates front and back.
// Back: one LED per cycle while led is not stalled, through the single read
//   port of the brightness memory; loading the next job is a step of its own.
// A level item reaches led via the front, the queue and job/s1/s2/out regs.
// Reset clears the smoothed levels and marks every bar dark; there is no
//   clearing pass, so items are taken right after reset.
// A stall on led freezes the back pipeline; the queue then fills and level
//   ready drops once the front cannot hand off its job.
`default_nettype none

module led_bar_graph_fader_core #(
    parameter int BAR_COUNT   = lbgf_pkg::BAR_COUNT_DEF,
    parameter int LEDS_IN_BAR = lbgf_pkg::LEDS_IN_BAR_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    lbgf_in_if.sink                          level,
    lbgf_out_if.source                       led,
    input  logic                             write_en,
    input  logic [lbgf_pkg::CFG_IDX_W-1:0]   reg_index,
    input  logic [lbgf_pkg::CFG_DATA_W-1:0]  write_data
);

    lbgf_pkg::cfg_t  cfg_reg, cfg_next;
    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_valid;
    lbgf_pkg::job_t  q_push_job;
    lbgf_pkg::job_t  q_head_job;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (write_en)
        begin
            case (lbgf_pkg::cfg_idx_t'(reg_index))
                lbgf_pkg::CFG_FADE_STEP: cfg_next.fade_step = write_data[7:0];
                lbgf_pkg::CFG_ALPHA:     cfg_next.alpha     = write_data;
                lbgf_pkg::CFG_PERCENT:   cfg_next.percent   = write_data[6:0];
                lbgf_pkg::CFG_HUE_BASE:  cfg_next.hue_base  = write_data[7:0];
                lbgf_pkg::CFG_HUE_STEP:  cfg_next.hue_step  = write_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fade_step <= lbgf_pkg::FADE_STEP_RST;
            cfg_reg.alpha     <= lbgf_pkg::ALPHA_RST;
            cfg_reg.percent   <= lbgf_pkg::PCT_RST;
            cfg_reg.hue_base  <= lbgf_pkg::HUE_BASE_RST;
            cfg_reg.hue_step  <= lbgf_pkg::HUE_STEP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lbgf_front #(
        .BAR_COUNT   (BAR_COUNT),
        .LEDS_IN_BAR (LEDS_IN_BAR)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .level    (level),
        .cfg      (cfg_reg),
        .push     (q_push),
        .push_job (q_push_job),
        .full     (q_full)
    );

    lbgf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_job  (q_push_job),
        .full      (q_full),
        .pop       (q_pop),
        .head_job  (q_head_job),
        .not_empty (q_valid)
    );

    lbgf_back #(
        .BAR_COUNT   (BAR_COUNT),
        .LEDS_IN_BAR (LEDS_IN_BAR)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_job   (q_head_job),
        .q_pop   (q_pop),
        .led     (led)
    );

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("job queue overflow");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("job queue underflow");

    a_front_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (level.valid && level.ready && ({4'b0, level.bar_index} < 7'(BAR_COUNT)))
        |=> !level.ready)
        else $error("front took a level transfer while busy");

endmodule

`default_nettype wire
